>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition");

// antecedent implies consequent on the next clock
`define ASSERT_IMPL_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/asa_pkg.sv
// ----------------------------------------------------------------------------
// asa_pkg
// shared types and constants of the aligned stack allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asa_pkg;

    localparam int WORD_W = 32;
    localparam int SIZE_W = 27;
    localparam int ADDR_W = 32;
    localparam int CAP_W  = 27;

    localparam logic [WORD_W-1:0] RESET_CAPACITY = 32'd65536;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_GROW  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RC_OK       = 2'd0,
        RC_FULL     = 2'd1,
        RC_EMPTY    = 2'd2,
        RC_MISMATCH = 2'd3
    } t_result_code;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic calc;
        logic commit;
        logic push;
        logic pop;
        logic clear;
        logic grow;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic empty;
        logic full;
        logic match;
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/aligned_stack_allocator.sv
// ----------------------------------------------------------------------------
// aligned_stack_allocator
// lifo bump allocator over a pool of offsets with an entry stack
// sequence: a request accepted in idle reads the entry stack top into a
//   register, calc then forms the split add/compare, and done commits the
//   result into the output register once it is free or being drained; no
//   new request is taken until that commit
// reset: synchronous active-low; counters, index and state clear, capacity
//   loads 65536; the entry stack is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aligned_stack_allocator #(
    parameter int MAX_ENTRIES = 64,
    parameter int ALIGN       = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // configuration: initial capacity, also loads working capacity
    input  wire                         i_cfg_we,
    input  wire [asa_pkg::CAP_W-1:0]    i_cfg_wdata,
    // request channel
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire [1:0]                   i_operation,
    input  wire [asa_pkg::SIZE_W-1:0]   i_size,
    input  wire [asa_pkg::ADDR_W-1:0]   i_address,
    // result channel
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [asa_pkg::WORD_W-1:0]  o_offset,
    output logic                        o_fallback,
    output logic [1:0]                  o_status,
    output logic                        o_grown,
    output logic [asa_pkg::WORD_W-1:0]  o_capacity_now,
    output logic [asa_pkg::WORD_W-1:0]  o_in_use,
    output logic [asa_pkg::WORD_W-1:0]  o_peak
);

    // command and status between the sequencer and the datapath
    asa_pkg::t_cmd       cmd;
    asa_pkg::t_dp_status dp_status;

    // sequencer: idle accepts a request, calc forms the aligned end,
    // span, saturated sums and the free check, done commits the result
    // once the output register is free or being drained
    asa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (dp_status)
    );

    // datapath: entry stack memory read at the top on accept, bump index
    // kept with its remainder modulo the alignment, capacity, in-use and
    // peak registers, and the registered result fields
    asa_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ALIGN       (ALIGN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (dp_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_operation    (i_operation),
        .i_size         (i_size),
        .i_address      (i_address),
        .o_offset       (o_offset),
        .o_fallback     (o_fallback),
        .o_status_code  (o_status),
        .o_grown        (o_grown),
        .o_capacity_now (o_capacity_now),
        .o_in_use       (o_in_use),
        .o_peak         (o_peak)
    );

endmodule

`default_nettype wire

>>> rtl/asa_ctrl.sv
// ----------------------------------------------------------------------------
// asa_ctrl
// request sequencer: accept, calculate, commit into the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module asa_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output asa_pkg::t_cmd       o_cmd,
    input  asa_pkg::t_dp_status i_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_state == S_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // no request is taken while reset is held
    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid && i_rst_n;
        o_cmd.calc   = (r_state == S_CALC);
        o_cmd.commit = (r_state == S_DONE) && slot_free;
        o_cmd.push   = o_cmd.commit && (i_status.op == asa_pkg::OP_ALLOC) && !i_status.full;
        o_cmd.pop    = o_cmd.commit && (i_status.op == asa_pkg::OP_FREE) && !i_status.empty
                       && i_status.match;
        o_cmd.clear  = o_cmd.commit && (i_status.op == asa_pkg::OP_CLEAR);
        o_cmd.grow   = o_cmd.commit && (i_status.op == asa_pkg::OP_GROW);
    end

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `ASSERT_NEVER(a_push_pop, o_cmd.push && o_cmd.pop)
    `ASSERT_IMPL_NEXT(a_commit_valid, o_cmd.commit, r_out_valid)
    `ASSERT_IMPL_NEXT(a_load_calc, o_cmd.load, r_state == S_CALC)

endmodule

`default_nettype wire

>>> rtl/asa_dp.sv
// ----------------------------------------------------------------------------
// asa_dp
// entry stack memory, bump index, capacity and usage counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module asa_dp #(
    parameter int MAX_ENTRIES = 64,
    parameter int ALIGN       = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  asa_pkg::t_cmd               i_cmd,
    output asa_pkg::t_dp_status         o_status,
    input  wire                         i_cfg_we,
    input  wire [asa_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  wire [1:0]                   i_operation,
    input  wire [asa_pkg::SIZE_W-1:0]   i_size,
    input  wire [asa_pkg::ADDR_W-1:0]   i_address,
    output logic [asa_pkg::WORD_W-1:0]  o_offset,
    output logic                        o_fallback,
    output logic [1:0]                  o_status_code,
    output logic                        o_grown,
    output logic [asa_pkg::WORD_W-1:0]  o_capacity_now,
    output logic [asa_pkg::WORD_W-1:0]  o_in_use,
    output logic [asa_pkg::WORD_W-1:0]  o_peak
);

    localparam int WW      = asa_pkg::WORD_W;
    localparam int SW      = asa_pkg::SIZE_W;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int REM_W   = $clog2(ALIGN + 1);
    localparam int EST_W   = REM_W + 1;
    localparam int RECIP_W = SW + 1;
    localparam int PROD_W  = SW + RECIP_W;
    localparam int QA_W    = RECIP_W + REM_W;
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << SW) / ALIGN);
    localparam logic [REM_W-1:0]   ALIGN_V = REM_W'(ALIGN);

    typedef struct packed {
        logic [WW-1:0]    start;
        logic [WW-1:0]    span;
        logic [SW-1:0]    size;
        logic             outside;
        logic [REM_W-1:0] prev_rem;
    } t_entry;

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd;
    t_entry wr_entry;

    // architectural state
    logic [CNT_W-1:0] r_count;
    logic [WW-1:0]    r_bump;
    logic [REM_W-1:0] r_rem;
    logic [WW-1:0]    r_cap;
    logic [WW-1:0]    r_in_use;
    logic [WW-1:0]    r_peak;

    // request and intermediate registers
    asa_pkg::t_op     r_op;
    logic [SW-1:0]    r_size;
    logic [WW-1:0]    r_addr;
    logic [RECIP_W-1:0] r_q;
    logic [WW:0]      r_aligned;
    logic             r_fit;
    logic [WW-1:0]    r_span_pool;
    logic [REM_W-1:0] r_new_rem;
    logic [WW-1:0]    r_add_pool;
    logic [WW-1:0]    r_add_fb;
    logic [WW-1:0]    r_sub;
    logic             r_match;
    logic [WW-1:0]    r_prev_idx;

    // result registers
    logic [WW-1:0]    r_offset;
    logic             r_fallback;
    logic [1:0]       r_status_code;
    logic             r_grown;
    logic [WW-1:0]    r_cap_out;
    logic [WW-1:0]    r_in_use_out;
    logic [WW-1:0]    r_peak_out;

    logic [REM_W-1:0] pad;
    logic [IDX_W-1:0] rd_idx;
    logic [PROD_W-1:0] prod;
    logic [QA_W-1:0]  est_full;
    logic [EST_W-1:0] est;
    logic [EST_W-1:0] est_sub;
    logic [WW+1:0]    end_sum;
    logic [WW:0]      sum_pool;
    logic [WW:0]      sum_fb;
    logic             full;
    logic             empty;
    logic [WW-1:0]    n_in_use;
    logic [WW-1:0]    n_peak;
    logic [WW-1:0]    n_cap;
    logic             grow_hit;
    asa_pkg::t_result_code code;

    assign full  = (r_count == CNT_W'(MAX_ENTRIES));
    assign empty = (r_count == '0);

    assign pad    = (r_rem == '0) ? '0 : ALIGN_V - r_rem;
    assign rd_idx = empty ? '0 : IDX_W'(r_count - 1'b1);
    assign prod   = PROD_W'(i_size) * PROD_W'(RECIP);

    // size mod align: reciprocal estimate is low by at most one
    assign est_full = QA_W'(r_size) - r_q * QA_W'(ALIGN_V);
    assign est      = est_full[EST_W-1:0];
    assign est_sub  = est - EST_W'(ALIGN);

    assign end_sum  = {1'b0, r_aligned} + (WW+2)'(r_size);
    assign sum_pool = {1'b0, r_in_use} + (WW+1)'(r_size) + (WW+1)'(pad);
    assign sum_fb   = {1'b0, r_in_use} + (WW+1)'(r_size);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= asa_pkg::t_op'(i_operation);
            r_size    <= i_size;
            r_addr    <= i_address;
            r_q       <= prod[PROD_W-1:SW];
            r_aligned <= {1'b0, r_bump} + (WW+1)'(pad);
        end
        if (i_cmd.calc) begin
            r_fit       <= (end_sum <= {2'b00, r_cap});
            r_span_pool <= WW'(r_size) + WW'(pad);
            r_new_rem   <= (est >= EST_W'(ALIGN)) ? est_sub[REM_W-1:0] : est[REM_W-1:0];
            r_add_pool  <= sum_pool[WW] ? '1 : sum_pool[WW-1:0];
            r_add_fb    <= sum_fb[WW] ? '1 : sum_fb[WW-1:0];
            r_sub       <= (r_in_use > r_rd.span) ? r_in_use - r_rd.span : '0;
            r_match     <= (r_rd.size == r_size) && (r_rd.outside || r_rd.start == r_addr);
            r_prev_idx  <= r_rd.start + WW'(r_rd.size) - r_rd.span;
        end
    end

    // entry stack
    always_comb begin
        wr_entry.start    = r_fit ? r_aligned[WW-1:0] : '0;
        wr_entry.span     = r_fit ? r_span_pool : WW'(r_size);
        wr_entry.size     = r_size;
        wr_entry.outside  = !r_fit;
        wr_entry.prev_rem = r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_count[IDX_W-1:0]] <= wr_entry;
        end
        if (i_cmd.load) begin
            r_rd <= r_mem[rd_idx];
        end
    end

    always_comb begin
        n_in_use = r_in_use;
        if (i_cmd.push) begin
            n_in_use = r_fit ? r_add_pool : r_add_fb;
        end else if (i_cmd.pop) begin
            n_in_use = r_sub;
        end else if (i_cmd.clear) begin
            n_in_use = '0;
        end
        grow_hit = i_cmd.grow && (r_peak > r_cap);
        n_cap    = grow_hit ? r_peak : r_cap;
        n_peak   = r_peak;
        if (i_cmd.push && (n_in_use > r_peak)) begin
            n_peak = n_in_use;
        end else if (i_cmd.grow) begin
            n_peak = '0;
        end
    end

    always_comb begin
        code = asa_pkg::RC_OK;
        case (r_op)
            asa_pkg::OP_ALLOC: begin
                if (full) begin
                    code = asa_pkg::RC_FULL;
                end
            end
            asa_pkg::OP_FREE: begin
                if (empty) begin
                    code = asa_pkg::RC_EMPTY;
                end else if (!r_match) begin
                    code = asa_pkg::RC_MISMATCH;
                end
            end
            default: begin
                code = asa_pkg::RC_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_bump   <= '0;
            r_rem    <= '0;
            r_cap    <= asa_pkg::RESET_CAPACITY;
            r_in_use <= '0;
            r_peak   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= WW'(i_cfg_wdata);
            end else if (i_cmd.commit) begin
                r_cap <= n_cap;
            end
            if (i_cmd.commit) begin
                r_in_use <= n_in_use;
                r_peak   <= n_peak;
            end
            if (i_cmd.push) begin
                r_count <= r_count + 1'b1;
                if (r_fit) begin
                    r_bump <= end_sum[WW-1:0];
                    r_rem  <= r_new_rem;
                end
            end else if (i_cmd.pop) begin
                r_count <= r_count - 1'b1;
                if (!r_rd.outside) begin
                    r_bump <= r_prev_idx;
                    r_rem  <= r_rd.prev_rem;
                end
            end else if (i_cmd.clear) begin
                r_count <= '0;
                r_bump  <= '0;
                r_rem   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_offset      <= (i_cmd.push && r_fit) ? r_aligned[WW-1:0] : '0;
            r_fallback    <= (i_cmd.push && !r_fit) ||
                             ((r_op == asa_pkg::OP_FREE) && !empty && r_rd.outside);
            r_status_code <= code;
            r_grown       <= grow_hit;
            r_cap_out     <= n_cap;
            r_in_use_out  <= n_in_use;
            r_peak_out    <= n_peak;
        end
    end

    assign o_status.op    = r_op;
    assign o_status.empty = empty;
    assign o_status.full  = full;
    assign o_status.match = r_match;

    assign o_offset       = r_offset;
    assign o_fallback     = r_fallback;
    assign o_status_code  = r_status_code;
    assign o_grown        = r_grown;
    assign o_capacity_now = r_cap_out;
    assign o_in_use       = r_in_use_out;
    assign o_peak         = r_peak_out;

    `ASSERT_NEVER(a_count_range, r_count > CNT_W'(MAX_ENTRIES))
    `ASSERT_IMPL_NEXT(a_push_count, i_cmd.push, r_count == $past(r_count) + 1'b1)
    `ASSERT_IMPL_NEXT(a_fb_pop_bump, i_cmd.pop && r_rd.outside, $stable(r_bump))

endmodule

`default_nettype wire

>>> bench/tb_aligned_stack_allocator.sv
// ----------------------------------------------------------------------------
// tb_aligned_stack_allocator
// self-checking bench for the lifo bump allocator: a cycle-free shadow of the
// entry stack, bump index and byte counters predicts every result; directed
// tests hit alignment, exact fit, fallback, mismatch, stack full and counter
// saturation, then random phases under several capacities with bursty
// request gaps and result back-pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aligned_stack_allocator;

    localparam int WORD_W      = asa_pkg::WORD_W;
    localparam int SIZE_W      = asa_pkg::SIZE_W;
    localparam int ADDR_W      = asa_pkg::ADDR_W;
    localparam int CAP_W       = asa_pkg::CAP_W;
    localparam int STACK_DEPTH = 64;
    localparam int ALIGN_BYTES = 16;
    localparam int CYCLE_LIMIT = 400000;
    // idle pad after the last result comes back; the pad also outlasts a
    // leftover result stall burst
    localparam int DRAIN_PAD   = 16;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    // one result as the block reports it
    typedef struct packed {
        logic [WORD_W-1:0]     offset;
        logic                  fallback;
        asa_pkg::t_result_code status;
        logic                  grown;
        logic [WORD_W-1:0]     capacity_now;
        logic [WORD_W-1:0]     in_use;
        logic [WORD_W-1:0]     peak;
    } t_alloc_result;

    // ------------------------------------------------------------------
    // dut signals, every input known from time zero
    // ------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CAP_W-1:0]    i_cfg_wdata = '0;
    logic                i_in_valid  = 1'b0;
    logic [1:0]          i_operation = asa_pkg::OP_CLEAR;
    logic [SIZE_W-1:0]   i_size      = '0;
    logic [ADDR_W-1:0]   i_address   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [WORD_W-1:0]   o_offset;
    logic                o_fallback;
    logic [1:0]          o_status;
    logic                o_grown;
    logic [WORD_W-1:0]   o_capacity_now;
    logic [WORD_W-1:0]   o_in_use;
    logic [WORD_W-1:0]   o_peak;

    aligned_stack_allocator #(
        .MAX_ENTRIES (STACK_DEPTH),
        .ALIGN       (ALIGN_BYTES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_size         (i_size),
        .i_address      (i_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_offset       (o_offset),
        .o_fallback     (o_fallback),
        .o_status       (o_status),
        .o_grown        (o_grown),
        .o_capacity_now (o_capacity_now),
        .o_in_use       (o_in_use),
        .o_peak         (o_peak)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow allocator state, updated when a request is accepted
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]  stk_start   [STACK_DEPTH];
    logic [WORD_W-1:0]  stk_span    [STACK_DEPTH];
    logic [SIZE_W-1:0]  stk_size    [STACK_DEPTH];
    logic               stk_outside [STACK_DEPTH];
    int unsigned        stk_depth   = 0;
    logic [WORD_W-1:0]  pool_index  = '0;
    logic [WORD_W-1:0]  pool_cap    = asa_pkg::RESET_CAPACITY;
    logic [WORD_W-1:0]  used_bytes  = '0;
    logic [WORD_W-1:0]  peak_bytes  = '0;

    t_alloc_result      pending_results[$];
    int unsigned        mismatch_count = 0;
    int unsigned        cycle_count    = 0;

    // idle controls, both off in the last phase
    bit                 sender_idle    = 1'b1;
    bit                 receiver_idle  = 1'b1;
    int unsigned        stall_left     = 0;

    // bump index rounded up to the alignment, 64 bits so it never wraps
    function automatic logic [63:0] aligned_index();
        return ((64'(pool_index) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    // apply one request to the shadow state and return the expected result
    function automatic t_alloc_result predict_allocator(asa_pkg::t_op op,
                                                        logic [SIZE_W-1:0] sz,
                                                        logic [ADDR_W-1:0] ad);
        t_alloc_result     r;
        logic [63:0]       aligned;
        logic [63:0]       sum;
        logic [WORD_W-1:0] span;
        int unsigned       k;
        r = '0;
        r.status = asa_pkg::RC_OK;
        case (op)
            asa_pkg::OP_ALLOC: begin
                if (stk_depth >= STACK_DEPTH) begin
                    r.status = asa_pkg::RC_FULL;
                end else begin
                    k = stk_depth;
                    aligned = aligned_index();
                    stk_size[k] = sz;
                    if (aligned + 64'(sz) > 64'(pool_cap)) begin
                        // does not fit: outside entry, index untouched
                        stk_start[k]   = '0;
                        span           = 32'(sz);
                        stk_outside[k] = 1'b1;
                        r.fallback     = 1'b1;
                    end else begin
                        stk_start[k]   = aligned[31:0];
                        span           = 32'(aligned + 64'(sz) - 64'(pool_index));
                        stk_outside[k] = 1'b0;
                        pool_index     = 32'(aligned + 64'(sz));
                        r.offset       = aligned[31:0];
                    end
                    stk_span[k] = span;
                    stk_depth   = k + 1;
                    sum = 64'(used_bytes) + 64'(span);
                    used_bytes = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
                    if (used_bytes > peak_bytes) begin
                        peak_bytes = used_bytes;
                    end
                end
            end
            asa_pkg::OP_FREE: begin
                if (stk_depth == 0) begin
                    r.status = asa_pkg::RC_EMPTY;
                end else begin
                    k = stk_depth - 1;
                    r.fallback = stk_outside[k];
                    if (stk_size[k] != sz || (!stk_outside[k] && stk_start[k] != ad)) begin
                        r.status = asa_pkg::RC_MISMATCH;
                    end else begin
                        if (!stk_outside[k]) begin
                            pool_index = stk_start[k] + 32'(stk_size[k]) - stk_span[k];
                        end
                        used_bytes = (used_bytes > stk_span[k]) ? used_bytes - stk_span[k] : '0;
                        stk_depth  = k;
                    end
                end
            end
            asa_pkg::OP_CLEAR: begin
                stk_depth  = 0;
                pool_index = '0;
                used_bytes = '0;
            end
            default: begin
                if (peak_bytes > pool_cap) begin
                    pool_cap = peak_bytes;
                    r.grown  = 1'b1;
                end
                peak_bytes = '0;
            end
        endcase
        r.capacity_now = pool_cap;
        r.in_use       = used_bytes;
        r.peak         = peak_bytes;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // present one request, hold it through stalls, record its prediction
    task automatic send_request(input asa_pkg::t_op op, input logic [SIZE_W-1:0] sz,
                                input logic [ADDR_W-1:0] ad);
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_size      <= sz;
        i_address   <= ad;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_allocator(op, sz, ad));
    endtask

    // well-formed free of the top entry; address only matters for pool entries
    task automatic free_top();
        logic [SIZE_W-1:0] sz;
        logic [ADDR_W-1:0] ad;
        sz = SIZE_W'($urandom);
        ad = $urandom;
        if (stk_depth != 0) begin
            sz = stk_size[stk_depth-1];
            if (!stk_outside[stk_depth-1]) begin
                ad = stk_start[stk_depth-1];
            end
        end
        send_request(asa_pkg::OP_FREE, sz, ad);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // capacity register write, only with the block idle
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        pool_cap = 32'(value);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: bursty stall and checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
            stall_left  = $urandom_range(1, 14) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_alloc_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request outstanding, expected none, actual %0h",
                         $time, o_offset);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("offset", want.offset, o_offset);
                check_field("fallback", 32'(want.fallback), 32'(o_fallback));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("grown", 32'(want.grown), 32'(o_grown));
                check_field("capacity_now", want.capacity_now, o_capacity_now);
                check_field("in_use", want.in_use, o_in_use);
                check_field("peak", want.peak, o_peak);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every operation, alignment, exact fit, fallback and mismatches
    task automatic test_basic_ops();
        send_request(asa_pkg::OP_FREE, '0, '0);                  // free on empty stack
        send_request(asa_pkg::OP_GROW, '0, '0);                  // nothing to grow into
        send_request(asa_pkg::OP_CLEAR, SIZE_MAX, 32'hFFFF_FFFF);
        send_request(asa_pkg::OP_ALLOC, 27'd1, '0);              // offset 0, index 1
        send_request(asa_pkg::OP_ALLOC, 27'd0, '0);              // rounds up to 16
        send_request(asa_pkg::OP_ALLOC, 27'd17, '0);
        send_request(asa_pkg::OP_FREE, 27'd17, 32'd17);          // wrong address
        send_request(asa_pkg::OP_FREE, 27'd16, 32'd16);          // wrong size
        send_request(asa_pkg::OP_FREE, 27'd17, 32'd16);          // index back to 16
        send_request(asa_pkg::OP_ALLOC, SIZE_MAX, '0);           // outside the pool
        send_request(asa_pkg::OP_FREE, SIZE_MAX, 32'hFFFF_FFFF); // address ignored
        send_request(asa_pkg::OP_ALLOC, 27'd65520, '0);          // ends exactly at capacity
        send_request(asa_pkg::OP_ALLOC, 27'd1, '0);              // aligned end one past
        send_request(asa_pkg::OP_FREE, 27'd1, '0);
        send_request(asa_pkg::OP_FREE, SIZE_MAX, 32'hFFFF_FFFF);
        send_request(asa_pkg::OP_FREE, 27'd65520, 32'hFFFF_FFFF);
        send_request(asa_pkg::OP_GROW, '0, '0);                  // peak above capacity
        send_request(asa_pkg::OP_GROW, '0, '0);                  // peak just cleared
        send_request(asa_pkg::OP_CLEAR, '0, '0);
        send_request(asa_pkg::OP_FREE, 27'd3, 32'd3);
    endtask

    // fill the entry stack, overflow it, then unwind
    task automatic test_stack_full();
        send_request(asa_pkg::OP_CLEAR, '0, '0);
        repeat (STACK_DEPTH) begin
            send_request(asa_pkg::OP_ALLOC, 27'($urandom_range(0, 64)), $urandom);
        end
        send_request(asa_pkg::OP_ALLOC, 27'd5, '0);              // no room on the stack
        send_request(asa_pkg::OP_FREE, stk_size[STACK_DEPTH-1] + 27'd1,
                     stk_start[STACK_DEPTH-1]);
        while (stk_depth != 0) free_top();
        send_request(asa_pkg::OP_FREE, '0, '0);
    endtask

    // saturating counters, grow to full range, alignment past 32 bits
    task automatic test_saturation();
        logic [63:0] room;
        send_request(asa_pkg::OP_CLEAR, '0, '0);
        send_request(asa_pkg::OP_GROW, '0, '0);
        write_capacity('0);
        send_request(asa_pkg::OP_ALLOC, '0, '0);                 // zero size fits zero capacity
        repeat (33) send_request(asa_pkg::OP_ALLOC, SIZE_MAX, $urandom);
        free_top();                                              // subtract from saturated total
        free_top();
        send_request(asa_pkg::OP_GROW, '0, '0);                  // capacity to all ones
        send_request(asa_pkg::OP_CLEAR, '0, '0);
        // walk the index up to just below the top of the 32-bit range
        while (64'(pool_cap) - aligned_index() > 64'(SIZE_MAX) + ALIGN_BYTES) begin
            send_request(asa_pkg::OP_ALLOC, SIZE_MAX, '0);
        end
        room = 64'(pool_cap) - aligned_index();
        send_request(asa_pkg::OP_ALLOC, 27'(room - 5), '0);
        send_request(asa_pkg::OP_ALLOC, '0, '0);                 // aligned index beyond 2^32-1
        send_request(asa_pkg::OP_ALLOC, 27'd1, '0);
        free_top();
        free_top();
        free_top();
        send_request(asa_pkg::OP_CLEAR, '0, '0);
        write_capacity(asa_pkg::RESET_CAPACITY[CAP_W-1:0]);
    endtask

    // one random phase at a given capacity
    task automatic run_traffic(input logic [CAP_W-1:0] cap, input int unsigned n_items,
                               input bit allow_idle);
        asa_pkg::t_op      op;
        logic [SIZE_W-1:0] sz;
        logic [ADDR_W-1:0] ad;
        logic [63:0]       room;
        int unsigned       pick;
        if (!allow_idle) begin
            sender_idle   = 1'b0;
            receiver_idle = 1'b0;
        end
        write_capacity(cap);
        for (int unsigned i = 0; i < n_items; i++) begin
            // idle on or off in stretches
            if (i % 50 == 0) begin
                sender_idle   = allow_idle && ($urandom_range(0, 3) != 0);
                receiver_idle = allow_idle && ($urandom_range(0, 3) != 0);
            end
            ad = $urandom;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: sz = SIZE_W'($urandom_range(0, 256));
                6, 7:             sz = SIZE_W'($urandom_range(0, 8192));
                8:                sz = SIZE_W'($urandom);
                default: begin
                    // exact fit or one byte over
                    room = (aligned_index() <= 64'(pool_cap)) ?
                           64'(pool_cap) - aligned_index() : 64'd0;
                    sz = (room > 64'(SIZE_MAX)) ? SIZE_MAX :
                         27'(room) + 27'($urandom_range(0, 1));
                end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_request(asa_pkg::OP_ALLOC, sz, ad);
            end else if (pick < 72) begin
                free_top();
            end else if (pick < 80) begin
                // broken free: one bit off in size or address
                if (stk_depth != 0) begin
                    sz = stk_size[stk_depth-1];
                    if (!stk_outside[stk_depth-1]) begin
                        ad = stk_start[stk_depth-1];
                    end
                end
                if ($urandom_range(0, 1) == 1) begin
                    sz = sz ^ (27'd1 << $urandom_range(0, SIZE_W - 1));
                end else begin
                    ad = ad ^ (32'd1 << $urandom_range(0, ADDR_W - 1));
                end
                send_request(asa_pkg::OP_FREE, sz, ad);
            end else if (pick < 87) begin
                send_request(asa_pkg::OP_GROW, sz, ad);
            end else if (pick < 90) begin
                send_request(asa_pkg::OP_CLEAR, sz, ad);
            end else begin
                op = asa_pkg::t_op'($urandom_range(0, 3));
                send_request(op, SIZE_W'($urandom), ad);
            end
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(27'd4096, 250, 1'b1);
        run_traffic(SIZE_MAX, 250, 1'b1);
        run_traffic('0, 120, 1'b1);
        run_traffic(27'($urandom_range(1, 200000)), 300, 1'b1);
        // last stretch runs back to back
        run_traffic(asa_pkg::RESET_CAPACITY[CAP_W-1:0], 250, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // sequencing, watchdog
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_stack_full();
        test_saturation();
        test_random_traffic();
        wait_results_drained();
        if (mismatch_count == 0) begin
            $display("PASS aligned_stack_allocator");
        end else begin
            $display("FAIL aligned_stack_allocator");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_results.size());
        $display("FAIL aligned_stack_allocator");
        $finish;
    end

endmodule
